// File: hw/rtl/tlsv_pkg.sv
// Shared types and constants for the tone table and saturation/vibrance core.
// Holds the item structs, configuration struct, codes and fixed-point widths.
// Depends on nothing; every other file refers to it by scoped names.
package tlsv_pkg;

   localparam int TABLE_DEPTH  = 256;
   localparam int TABLE_ADDR_W = $clog2(TABLE_DEPTH);

   localparam int CHAN_W      = 8;
   localparam int GAIN_W      = 18;
   localparam int CSR_DATA_W  = GAIN_W;
   localparam int CSR_INDEX_W = 2;

   localparam int FRAC_W     = 16;
   localparam int LUMA_W     = 24;
   localparam int CHROMA_W   = FRAC_W + 1;
   localparam int DIV_STAGES = FRAC_W + 1;
   localparam int VPROD_W    = GAIN_W + CHROMA_W + 1;
   localparam int SCALE_W    = GAIN_W + 2;
   localparam int DIFF_W     = CHAN_W + FRAC_W + 1;
   localparam int PROD_W     = DIFF_W + SCALE_W;
   localparam int ACC_W      = 48;
   localparam int ADJ_STAGES = 5;

   localparam logic [15:0] LUMA_WR = 16'd19595;
   localparam logic [15:0] LUMA_WG = 16'd38470;
   localparam logic [15:0] LUMA_WB = 16'd7471;

   localparam logic [CHROMA_W-1:0] ONE_Q16 = {1'b1, {FRAC_W{1'b0}}};
   localparam logic [GAIN_W-1:0] SAT_GAIN_RESET = {{(GAIN_W-FRAC_W-1){1'b0}}, 1'b1,
                                                   {FRAC_W{1'b0}}};
   localparam logic signed [ACC_W-1:0] ACC_ROUND = {{(ACC_W-32){1'b0}}, 32'h8000_0000};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TONE_ENABLE = 2'd0,
      CSR_SAT_ENABLE  = 2'd1,
      CSR_SAT_GAIN    = 2'd2,
      CSR_VIB_GAIN    = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_PIXEL       = 1'b0,
      OP_TABLE_WRITE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      SEL_RED   = 2'd0,
      SEL_GREEN = 2'd1,
      SEL_BLUE  = 2'd2
   } table_select_type;

   typedef struct packed {
      logic              opcode;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
      logic              line_end;
      logic [1:0]        table_select;
      logic [7:0]        table_index;
      logic [CHAN_W-1:0] table_value;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
      logic [CHAN_W-1:0] out_alpha;
      logic              out_line_end;
   } rsp_type;

   typedef struct packed {
      logic                     tone_lut_enable;
      logic                     saturation_enable;
      logic [GAIN_W-1:0]        saturation_gain;
      logic signed [GAIN_W-1:0] vibrance_gain;
   } cfg_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
      logic              line_end;
   } pix_type;

   typedef struct packed {
      pix_type             pix;
      logic [LUMA_W-1:0]   luma;
      logic [CHROMA_W-1:0] chroma;
   } chroma_type;

endpackage

// File: hw/rtl/tone_lut_saturation_vibrance_core.sv
// Tone table and saturation/vibrance core for an RGBA pixel stream. Each pixel
// item passes its red, green and blue channels through per-channel 256-entry tone
// tables when tone_lut_enable is set, then, when saturation_enable is set, scales
// each channel about the pixel's luma by saturation_gain plus vibrance_gain
// weighted by how muted the pixel is, rounding half up and clamping to 0..255.
// Alpha and the line-end flag pass through untouched. A table-write item stores
// one byte into the table chosen by table_select and yields no result; a select
// of three is ignored. Table contents are undefined after reset, so software must
// write every entry that a pixel may look up before enabling the tone stage.
// The core takes one item per clock while req_stall is low. A pixel passes
// through 23 registers: one for the registered table read, seventeen for the
// luma stage and the bit-per-stage chroma divider, and five for the vibrance,
// scale, multiply, accumulate and result registers. Every stage carries its own
// valid bit and moves up into an empty slot, so input is still taken while a
// result waits on rsp_stall until the pipeline is genuinely full.
// Configuration registers are written through the csr_ port and must only
// change while no pixel is in flight.
// Depends on tlsv_pkg, tlsv_tone, tlsv_chroma and tlsv_adjust.
module tone_lut_saturation_vibrance_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  tlsv_pkg::req_type                     req_item,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output tlsv_pkg::rsp_type                     rsp_item,
   input  logic                                  csr_write_enable,
   input  logic [tlsv_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [tlsv_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   tlsv_pkg::cfg_type    cfg_ff, cfg_in;
   tlsv_pkg::pix_type    tone_pix;
   tlsv_pkg::chroma_type chroma_item;
   logic                 tone_valid, tone_stall;
   logic                 chroma_valid, chroma_stall;

   // Register writes; the enables take the low data bit, the gains all 18 bits.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            tlsv_pkg::CSR_TONE_ENABLE: cfg_in.tone_lut_enable   = csr_write_data[0];
            tlsv_pkg::CSR_SAT_ENABLE:  cfg_in.saturation_enable = csr_write_data[0];
            tlsv_pkg::CSR_SAT_GAIN:    cfg_in.saturation_gain   = csr_write_data;
            tlsv_pkg::CSR_VIB_GAIN:    cfg_in.vibrance_gain     = $signed(csr_write_data);
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tone_lut_enable   <= 1'b0;
         cfg_ff.saturation_enable <= 1'b0;
         cfg_ff.saturation_gain   <= tlsv_pkg::SAT_GAIN_RESET;
         cfg_ff.vibrance_gain     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Table access and tone mapping.
   tlsv_tone u_tone (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_item   (req_item),
      .out_valid (tone_valid),
      .out_stall (tone_stall),
      .out_pix   (tone_pix)
   );

   // Luma and chroma through the pipelined divider.
   tlsv_chroma u_chroma (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (tone_valid),
      .in_stall  (tone_stall),
      .in_pix    (tone_pix),
      .out_valid (chroma_valid),
      .out_stall (chroma_stall),
      .out_item  (chroma_item)
   );

   // Scale, rounding, clamp and the result register.
   tlsv_adjust u_adjust (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (chroma_valid),
      .in_stall  (chroma_stall),
      .in_item   (chroma_item),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_item  (rsp_item)
   );

   // With no result pending every stage can move, so the input is never held.
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with an empty result register");

endmodule

// File: hw/rtl/tlsv_tone.sv
// Tone stage: three 256-entry tone tables, written by table-write items and
// read by pixel items, with the table or raw channel selected by tone_lut_enable.
// Depends on tlsv_pkg.
module tlsv_tone (
   input  logic              clock,
   input  logic              reset,
   input  tlsv_pkg::cfg_type cfg,
   input  logic              in_valid,
   output logic              in_stall,
   input  tlsv_pkg::req_type in_item,
   output logic              out_valid,
   input  logic              out_stall,
   output tlsv_pkg::pix_type out_pix
);

   logic [tlsv_pkg::CHAN_W-1:0] red_mem   [tlsv_pkg::TABLE_DEPTH];
   logic [tlsv_pkg::CHAN_W-1:0] green_mem [tlsv_pkg::TABLE_DEPTH];
   logic [tlsv_pkg::CHAN_W-1:0] blue_mem  [tlsv_pkg::TABLE_DEPTH];

   logic [tlsv_pkg::CHAN_W-1:0] red_rd_ff, green_rd_ff, blue_rd_ff;
   tlsv_pkg::pix_type           pix_ff;
   logic                        valid_ff, valid_in;
   logic                        load, accept, is_write;
   logic [2:0]                  wr_sel;
   logic [tlsv_pkg::TABLE_ADDR_W-1:0] wr_addr;

   assign load     = !valid_ff || !out_stall;
   assign in_stall = !load;
   assign accept   = in_valid && load;
   assign is_write = accept && (in_item.opcode == tlsv_pkg::OP_TABLE_WRITE);
   assign wr_addr  = in_item.table_index[tlsv_pkg::TABLE_ADDR_W-1:0];

   // A select code that names no table leaves all three untouched.
   always_comb begin
      wr_sel = 3'b000;
      unique case (in_item.table_select)
         tlsv_pkg::SEL_RED:   wr_sel[0] = is_write;
         tlsv_pkg::SEL_GREEN: wr_sel[1] = is_write;
         tlsv_pkg::SEL_BLUE:  wr_sel[2] = is_write;
         default:             wr_sel    = 3'b000;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = in_valid && (in_item.opcode == tlsv_pkg::OP_PIXEL);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_sel[0]) begin
         red_mem[wr_addr] <= in_item.table_value;
      end
      if (wr_sel[1]) begin
         green_mem[wr_addr] <= in_item.table_value;
      end
      if (wr_sel[2]) begin
         blue_mem[wr_addr] <= in_item.table_value;
      end
      if (load) begin
         red_rd_ff   <= red_mem[in_item.red[tlsv_pkg::TABLE_ADDR_W-1:0]];
         green_rd_ff <= green_mem[in_item.green[tlsv_pkg::TABLE_ADDR_W-1:0]];
         blue_rd_ff  <= blue_mem[in_item.blue[tlsv_pkg::TABLE_ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff.red      <= in_item.red;
         pix_ff.green    <= in_item.green;
         pix_ff.blue     <= in_item.blue;
         pix_ff.alpha    <= in_item.alpha;
         pix_ff.line_end <= in_item.line_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign out_valid = valid_ff;

   always_comb begin
      out_pix = pix_ff;
      if (cfg.tone_lut_enable) begin
         out_pix.red   = red_rd_ff;
         out_pix.green = green_rd_ff;
         out_pix.blue  = blue_rd_ff;
      end
   end

   // A table write never becomes a pixel in the pipeline.
   a_write_no_pixel: assert property (@(posedge clock) disable iff (reset)
      is_write |=> !valid_ff)
      else $error("table write produced a pixel");

endmodule

// File: hw/rtl/tlsv_chroma.sv
// Chroma stage: luma, channel maximum and minimum, then a pipelined restoring
// divider that forms (max-min)/max in Q1.16, one quotient bit per stage.
// Depends on tlsv_pkg.
module tlsv_chroma (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  tlsv_pkg::pix_type    in_pix,
   output logic                 out_valid,
   input  logic                 out_stall,
   output tlsv_pkg::chroma_type out_item
);

   typedef struct packed {
      tlsv_pkg::pix_type                 pix;
      logic [tlsv_pkg::LUMA_W-1:0]       luma;
      logic [tlsv_pkg::CHAN_W-1:0]       peak;
      logic [tlsv_pkg::CHAN_W-1:0]       rem;
      logic [tlsv_pkg::CHROMA_W-1:0]     quo;
      logic                              peak_zero;
   } div_type;

   logic [tlsv_pkg::DIV_STAGES-1:0] valid_ff, valid_in;
   logic [tlsv_pkg::DIV_STAGES:0]   ready;
   div_type                         stage_ff [tlsv_pkg::DIV_STAGES];
   div_type                         stage_in [tlsv_pkg::DIV_STAGES];
   logic [tlsv_pkg::CHAN_W:0]       trial    [tlsv_pkg::FRAC_W];
   logic [tlsv_pkg::FRAC_W-1:0]     take_bit;
   logic [tlsv_pkg::CHAN_W-1:0]     peak, low;

   always_comb begin
      ready[tlsv_pkg::DIV_STAGES] = !out_stall;
      for (int k = tlsv_pkg::DIV_STAGES - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in[0] = ready[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < tlsv_pkg::DIV_STAGES; k++) begin
         valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   assign in_stall = !ready[0];

   // Front stage: luma, extremes and the integer quotient bit, which is set
   // only when the minimum is zero (then the difference equals the maximum).
   always_comb begin
      peak = in_pix.red;
      low  = in_pix.red;
      if (in_pix.green > peak) begin
         peak = in_pix.green;
      end
      if (in_pix.green < low) begin
         low = in_pix.green;
      end
      if (in_pix.blue > peak) begin
         peak = in_pix.blue;
      end
      if (in_pix.blue < low) begin
         low = in_pix.blue;
      end
      stage_in[0].pix       = in_pix;
      stage_in[0].luma      = tlsv_pkg::LUMA_W'(tlsv_pkg::LUMA_WR) *
                              tlsv_pkg::LUMA_W'(in_pix.red) +
                              tlsv_pkg::LUMA_W'(tlsv_pkg::LUMA_WG) *
                              tlsv_pkg::LUMA_W'(in_pix.green) +
                              tlsv_pkg::LUMA_W'(tlsv_pkg::LUMA_WB) *
                              tlsv_pkg::LUMA_W'(in_pix.blue);
      stage_in[0].peak      = peak;
      stage_in[0].peak_zero = (peak == '0);
      if ((low == '0) && (peak != '0)) begin
         stage_in[0].rem = '0;
         stage_in[0].quo = tlsv_pkg::ONE_Q16;
      end else begin
         stage_in[0].rem = peak - low;
         stage_in[0].quo = '0;
      end

      // One fractional quotient bit per stage, most significant first.
      for (int k = 1; k < tlsv_pkg::DIV_STAGES; k++) begin
         trial[k-1]    = {stage_ff[k-1].rem, 1'b0};
         take_bit[k-1] = trial[k-1] >= {1'b0, stage_ff[k-1].peak};
         stage_in[k]   = stage_ff[k-1];
         if (take_bit[k-1]) begin
            stage_in[k].rem = tlsv_pkg::CHAN_W'(trial[k-1] - {1'b0, stage_ff[k-1].peak});
         end else begin
            stage_in[k].rem = trial[k-1][tlsv_pkg::CHAN_W-1:0];
         end
         stage_in[k].quo[tlsv_pkg::FRAC_W-k] = take_bit[k-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < tlsv_pkg::DIV_STAGES; k++) begin
         if (ready[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign out_valid       = valid_ff[tlsv_pkg::DIV_STAGES-1];
   assign out_item.pix    = stage_ff[tlsv_pkg::DIV_STAGES-1].pix;
   assign out_item.luma   = stage_ff[tlsv_pkg::DIV_STAGES-1].luma;
   assign out_item.chroma = stage_ff[tlsv_pkg::DIV_STAGES-1].peak_zero ? '0 :
                            stage_ff[tlsv_pkg::DIV_STAGES-1].quo;

   a_chroma_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_item.chroma <= tlsv_pkg::ONE_Q16))
      else $error("chroma above one");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !stage_ff[tlsv_pkg::DIV_STAGES-1].peak_zero) |->
      (stage_ff[tlsv_pkg::DIV_STAGES-1].rem < stage_ff[tlsv_pkg::DIV_STAGES-1].peak))
      else $error("divider remainder not below divisor");

endmodule

// File: hw/rtl/tlsv_adjust.sv
// Adjust stage: saturation/vibrance scale, per-channel scaling about luma,
// rounding, clamping and the result register.
// Depends on tlsv_pkg.
module tlsv_adjust (
   input  logic                 clock,
   input  logic                 reset,
   input  tlsv_pkg::cfg_type    cfg,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  tlsv_pkg::chroma_type in_item,
   output logic                 out_valid,
   input  logic                 out_stall,
   output tlsv_pkg::rsp_type    out_item
);

   typedef struct packed {
      tlsv_pkg::pix_type                  pix;
      logic [tlsv_pkg::LUMA_W-1:0]        luma;
      logic signed [tlsv_pkg::VPROD_W-1:0] vprod;
   } vib_type;

   typedef struct packed {
      tlsv_pkg::pix_type                  pix;
      logic [tlsv_pkg::LUMA_W-1:0]        luma;
      logic signed [tlsv_pkg::SCALE_W-1:0] scale;
      logic signed [tlsv_pkg::DIFF_W-1:0]  diff_r;
      logic signed [tlsv_pkg::DIFF_W-1:0]  diff_g;
      logic signed [tlsv_pkg::DIFF_W-1:0]  diff_b;
   } scale_type;

   typedef struct packed {
      tlsv_pkg::pix_type                  pix;
      logic [tlsv_pkg::LUMA_W-1:0]        luma;
      logic signed [tlsv_pkg::PROD_W-1:0]  prod_r;
      logic signed [tlsv_pkg::PROD_W-1:0]  prod_g;
      logic signed [tlsv_pkg::PROD_W-1:0]  prod_b;
   } prod_type;

   typedef struct packed {
      tlsv_pkg::pix_type                  pix;
      logic signed [tlsv_pkg::ACC_W-1:0]   acc_r;
      logic signed [tlsv_pkg::ACC_W-1:0]   acc_g;
      logic signed [tlsv_pkg::ACC_W-1:0]   acc_b;
   } acc_type;

   localparam int S_VIB   = 0;
   localparam int S_SCALE = 1;
   localparam int S_PROD  = 2;
   localparam int S_ACC   = 3;
   localparam int S_OUT   = 4;

   logic [tlsv_pkg::ADJ_STAGES-1:0] valid_ff, valid_in;
   logic [tlsv_pkg::ADJ_STAGES:0]   ready;

   vib_type           vib_ff, vib_in;
   scale_type         scale_ff, scale_in;
   prod_type          prod_ff, prod_in;
   acc_type           acc_ff, acc_in;
   tlsv_pkg::rsp_type rsp_ff, rsp_in;

   logic signed [tlsv_pkg::CHROMA_W:0]  weight;
   logic signed [tlsv_pkg::VPROD_W-1:0] vib_shift;
   logic signed [tlsv_pkg::ACC_W-1:0]   luma_q32;

   // Round-half-up has already been added; the top bits are the floored value.
   function automatic logic [tlsv_pkg::CHAN_W-1:0] clamp_channel(
      input logic signed [tlsv_pkg::ACC_W-1:0] acc
   );
      logic [tlsv_pkg::CHAN_W-1:0] res;
      if (acc[tlsv_pkg::ACC_W-1]) begin
         res = '0;
      end else if (|acc[tlsv_pkg::ACC_W-2:2*tlsv_pkg::FRAC_W+tlsv_pkg::CHAN_W]) begin
         res = '1;
      end else begin
         res = acc[2*tlsv_pkg::FRAC_W +: tlsv_pkg::CHAN_W];
      end
      return res;
   endfunction

   function automatic logic signed [tlsv_pkg::DIFF_W-1:0] chan_diff(
      input logic [tlsv_pkg::CHAN_W-1:0] c,
      input logic [tlsv_pkg::LUMA_W-1:0] luma
   );
      return $signed({1'b0, c, {tlsv_pkg::FRAC_W{1'b0}}}) - $signed({1'b0, luma});
   endfunction

   always_comb begin
      ready[tlsv_pkg::ADJ_STAGES] = !out_stall;
      for (int k = tlsv_pkg::ADJ_STAGES - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in[0] = ready[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < tlsv_pkg::ADJ_STAGES; k++) begin
         valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   assign in_stall = !ready[0];

   always_comb begin
      // Vibrance weight (1 - chroma) and its product with the vibrance gain.
      weight       = $signed({1'b0, tlsv_pkg::ONE_Q16 - in_item.chroma});
      vib_in.pix   = in_item.pix;
      vib_in.luma  = in_item.luma;
      vib_in.vprod = $signed(cfg.vibrance_gain) * weight;

      // Scale in Q16 and the signed channel offsets from luma.
      vib_shift       = vib_ff.vprod >>> tlsv_pkg::FRAC_W;
      scale_in.pix    = vib_ff.pix;
      scale_in.luma   = vib_ff.luma;
      scale_in.scale  = $signed({{(tlsv_pkg::SCALE_W-tlsv_pkg::GAIN_W){1'b0}},
                                 cfg.saturation_gain}) +
                        $signed(vib_shift[tlsv_pkg::SCALE_W-1:0]);
      scale_in.diff_r = chan_diff(vib_ff.pix.red, vib_ff.luma);
      scale_in.diff_g = chan_diff(vib_ff.pix.green, vib_ff.luma);
      scale_in.diff_b = chan_diff(vib_ff.pix.blue, vib_ff.luma);

      prod_in.pix    = scale_ff.pix;
      prod_in.luma   = scale_ff.luma;
      prod_in.prod_r = scale_ff.diff_r * scale_ff.scale;
      prod_in.prod_g = scale_ff.diff_g * scale_ff.scale;
      prod_in.prod_b = scale_ff.diff_b * scale_ff.scale;

      luma_q32 = $signed({{(tlsv_pkg::ACC_W-tlsv_pkg::LUMA_W-tlsv_pkg::FRAC_W){1'b0}},
                          prod_ff.luma, {tlsv_pkg::FRAC_W{1'b0}}});
      acc_in.pix   = prod_ff.pix;
      acc_in.acc_r = luma_q32 + tlsv_pkg::ACC_W'(prod_ff.prod_r) + tlsv_pkg::ACC_ROUND;
      acc_in.acc_g = luma_q32 + tlsv_pkg::ACC_W'(prod_ff.prod_g) + tlsv_pkg::ACC_ROUND;
      acc_in.acc_b = luma_q32 + tlsv_pkg::ACC_W'(prod_ff.prod_b) + tlsv_pkg::ACC_ROUND;

      rsp_in.out_alpha    = acc_ff.pix.alpha;
      rsp_in.out_line_end = acc_ff.pix.line_end;
      if (cfg.saturation_enable) begin
         rsp_in.out_red   = clamp_channel(acc_ff.acc_r);
         rsp_in.out_green = clamp_channel(acc_ff.acc_g);
         rsp_in.out_blue  = clamp_channel(acc_ff.acc_b);
      end else begin
         rsp_in.out_red   = acc_ff.pix.red;
         rsp_in.out_green = acc_ff.pix.green;
         rsp_in.out_blue  = acc_ff.pix.blue;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[S_VIB]) begin
         vib_ff <= vib_in;
      end
      if (ready[S_SCALE]) begin
         scale_ff <= scale_in;
      end
      if (ready[S_PROD]) begin
         prod_ff <= prod_in;
      end
      if (ready[S_ACC]) begin
         acc_ff <= acc_in;
      end
      if (ready[S_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign out_valid = valid_ff[S_OUT];
   assign out_item  = rsp_ff;

   // Alpha and line end must leave exactly as they entered the last stage.
   a_passthrough: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[S_ACC] && ready[S_OUT]) |=>
      (out_item.out_alpha == $past(acc_ff.pix.alpha)) &&
      (out_item.out_line_end == $past(acc_ff.pix.line_end)))
      else $error("alpha or line end altered");

endmodule

// File: tb/tone_lut_saturation_vibrance_core_tb.sv
// Self-checking testbench for tone_lut_saturation_vibrance_core.
// Holds a pixel grading tracker class and the driving tasks in one module.
// Depends on tlsv_pkg and the core's RTL.
module tone_lut_saturation_vibrance_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Table writes leave nothing to wait on, so a settle allows for a pixel's full
   // path through the core plus some margin.
   localparam int SETTLE_CYCLES = 23 + 9;
   localparam logic [1:0] SEL_NONE = 2'd3;
   localparam longint Q16_ONE = 64'sd65536;
   localparam longint ROUND_HALF = 64'sh8000_0000;

   // The tracker keeps its own copy of the tone curves and the settings, grades
   // each accepted pixel in order and matches the results against that queue.
   class tone_grade_tracker;
      logic [tlsv_pkg::CHAN_W-1:0] red_curve [tlsv_pkg::TABLE_DEPTH];
      logic [tlsv_pkg::CHAN_W-1:0] green_curve [tlsv_pkg::TABLE_DEPTH];
      logic [tlsv_pkg::CHAN_W-1:0] blue_curve [tlsv_pkg::TABLE_DEPTH];
      tlsv_pkg::cfg_type cfg;
      tlsv_pkg::rsp_type awaited_pixels [$];
      int mismatches;

      function new();
         cfg.tone_lut_enable = 1'b0;
         cfg.saturation_enable = 1'b0;
         cfg.saturation_gain = tlsv_pkg::SAT_GAIN_RESET;
         cfg.vibrance_gain = '0;
         mismatches = 0;
      endfunction

      function void set_register(tlsv_pkg::csr_index_type idx,
                                 logic [tlsv_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            tlsv_pkg::CSR_TONE_ENABLE: cfg.tone_lut_enable = data[0];
            tlsv_pkg::CSR_SAT_ENABLE:  cfg.saturation_enable = data[0];
            tlsv_pkg::CSR_SAT_GAIN:    cfg.saturation_gain = data;
            tlsv_pkg::CSR_VIB_GAIN:    cfg.vibrance_gain = data;
            default: ;
         endcase
      endfunction

      // Pull one channel away from (or towards) the luma, round half up, clamp.
      function longint stretch(longint c, longint luma, longint scale);
         longint acc;
         acc = luma * Q16_ONE + (c * Q16_ONE - luma) * scale + ROUND_HALF;
         acc = acc >>> 32;
         if (acc < 0) return 0;
         if (acc > 255) return 255;
         return acc;
      endfunction

      function tlsv_pkg::rsp_type grade_pixel(tlsv_pkg::req_type it);
         longint r, g, b, luma, hi, lo, chroma, scale;
         tlsv_pkg::rsp_type res;
         r = it.red;
         g = it.green;
         b = it.blue;
         if (cfg.tone_lut_enable) begin
            r = red_curve[it.red];
            g = green_curve[it.green];
            b = blue_curve[it.blue];
         end
         if (cfg.saturation_enable) begin
            luma = longint'(tlsv_pkg::LUMA_WR) * r + longint'(tlsv_pkg::LUMA_WG) * g +
                   longint'(tlsv_pkg::LUMA_WB) * b;
            hi = (r > g) ? r : g;
            lo = (r < g) ? r : g;
            if (b > hi) hi = b;
            if (b < lo) lo = b;
            chroma = (hi == 0) ? 0 : ((hi - lo) <<< 16) / hi;
            scale = longint'(cfg.saturation_gain) +
                    ((longint'($signed(cfg.vibrance_gain)) * (Q16_ONE - chroma)) >>> 16);
            r = stretch(r, luma, scale);
            g = stretch(g, luma, scale);
            b = stretch(b, luma, scale);
         end
         res.out_red = r[tlsv_pkg::CHAN_W-1:0];
         res.out_green = g[tlsv_pkg::CHAN_W-1:0];
         res.out_blue = b[tlsv_pkg::CHAN_W-1:0];
         res.out_alpha = it.alpha;
         res.out_line_end = it.line_end;
         return res;
      endfunction

      // Table writes update the curves at once; a pixel queues its graded result.
      function void take_item(tlsv_pkg::req_type it);
         if (it.opcode == tlsv_pkg::OP_TABLE_WRITE) begin
            case (it.table_select)
               tlsv_pkg::SEL_RED:   red_curve[it.table_index] = it.table_value;
               tlsv_pkg::SEL_GREEN: green_curve[it.table_index] = it.table_value;
               tlsv_pkg::SEL_BLUE:  blue_curve[it.table_index] = it.table_value;
               default: ;
            endcase
         end else begin
            awaited_pixels = {awaited_pixels, grade_pixel(it)};
         end
      endfunction

      function void compare_field(string field, logic [tlsv_pkg::CHAN_W-1:0] want,
                                  logic [tlsv_pkg::CHAN_W-1:0] got);
         if (want !== got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void match_pixel(tlsv_pkg::rsp_type got);
         tlsv_pkg::rsp_type want;
         if (awaited_pixels.size() == 0) begin
            $display("%0t ns: result with no pixel outstanding, expected none, got %p",
                     $time, got);
            mismatches++;
            return;
         end
         want = awaited_pixels.pop_front();
         compare_field("out_red", want.out_red, got.out_red);
         compare_field("out_green", want.out_green, got.out_green);
         compare_field("out_blue", want.out_blue, got.out_blue);
         compare_field("out_alpha", want.out_alpha, got.out_alpha);
         compare_field("out_line_end", tlsv_pkg::CHAN_W'(want.out_line_end),
                       tlsv_pkg::CHAN_W'(got.out_line_end));
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   tlsv_pkg::req_type req_item;
   logic rsp_valid;
   logic rsp_stall;
   tlsv_pkg::rsp_type rsp_item;
   logic csr_write_enable;
   logic [tlsv_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [tlsv_pkg::CSR_DATA_W-1:0] csr_write_data;

   tone_grade_tracker tracker = new();

   // When quiet is set, neither side idles, so the pipeline runs at full rate.
   bit quiet = 1'b0;

   tone_lut_saturation_vibrance_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item(rsp_item),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic int draw_gap();
      return quiet ? 0 : $urandom_range(0, 16);
   endfunction

   function automatic tlsv_pkg::req_type make_pixel(int r, int g, int b, int a, bit le);
      tlsv_pkg::req_type it;
      it = '0;
      it.opcode = tlsv_pkg::OP_PIXEL;
      it.red = tlsv_pkg::CHAN_W'(r);
      it.green = tlsv_pkg::CHAN_W'(g);
      it.blue = tlsv_pkg::CHAN_W'(b);
      it.alpha = tlsv_pkg::CHAN_W'(a);
      it.line_end = le;
      return it;
   endfunction

   function automatic tlsv_pkg::req_type make_write(logic [1:0] sel, int idx, int val);
      tlsv_pkg::req_type it;
      it = '0;
      it.opcode = tlsv_pkg::OP_TABLE_WRITE;
      it.table_select = sel;
      it.table_index = 8'(idx);
      it.table_value = tlsv_pkg::CHAN_W'(val);
      return it;
   endfunction

   // A random pixel. Greys and fully saturated corners are favoured because they
   // sit on the edges of the chroma division; table fields carry noise.
   function automatic tlsv_pkg::req_type random_pixel();
      tlsv_pkg::req_type it;
      it.opcode = tlsv_pkg::OP_PIXEL;
      it.red = tlsv_pkg::CHAN_W'($urandom_range(0, 255));
      it.green = tlsv_pkg::CHAN_W'($urandom_range(0, 255));
      it.blue = tlsv_pkg::CHAN_W'($urandom_range(0, 255));
      case ($urandom_range(0, 5))
         0: begin
            it.green = it.red;
            it.blue = it.red;
         end
         1: begin
            it.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            it.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            it.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
         default: ;
      endcase
      it.alpha = tlsv_pkg::CHAN_W'($urandom_range(0, 255));
      it.line_end = 1'($urandom_range(0, 1));
      it.table_select = 2'($urandom_range(0, 3));
      it.table_index = 8'($urandom_range(0, 255));
      it.table_value = tlsv_pkg::CHAN_W'($urandom_range(0, 255));
      return it;
   endfunction

   function automatic tlsv_pkg::req_type random_write();
      tlsv_pkg::req_type it;
      it.opcode = tlsv_pkg::OP_TABLE_WRITE;
      it.red = tlsv_pkg::CHAN_W'($urandom_range(0, 255));
      it.green = tlsv_pkg::CHAN_W'($urandom_range(0, 255));
      it.blue = tlsv_pkg::CHAN_W'($urandom_range(0, 255));
      it.alpha = tlsv_pkg::CHAN_W'($urandom_range(0, 255));
      it.line_end = 1'($urandom_range(0, 1));
      it.table_select = ($urandom_range(0, 7) == 0) ? SEL_NONE : 2'($urandom_range(0, 2));
      it.table_index = 8'($urandom_range(0, 255));
      it.table_value = tlsv_pkg::CHAN_W'($urandom_range(0, 255));
      return it;
   endfunction

   // Called just after a falling edge. The payload is presented after a random
   // gap and held until the core takes it; valid is left high on return so that
   // a following item with no gap keeps the stream back to back.
   task automatic push_item(tlsv_pkg::req_type it);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_item(it);
      @(negedge clock);
   endtask

   // Stop sending, let every outstanding pixel come back, then wait out the
   // settle margin.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (tracker.awaited_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(tlsv_pkg::csr_index_type idx,
                                 logic [tlsv_pkg::CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      tracker.set_register(idx, data);
      @(negedge clock);
   endtask

   // All four registers are written back to back; enable stays high throughout.
   task automatic program_settings(bit tone, bit sat,
                                   logic [tlsv_pkg::CSR_DATA_W-1:0] gain,
                                   logic [tlsv_pkg::CSR_DATA_W-1:0] vib);
      write_register(tlsv_pkg::CSR_TONE_ENABLE, tlsv_pkg::CSR_DATA_W'(tone));
      write_register(tlsv_pkg::CSR_SAT_ENABLE, tlsv_pkg::CSR_DATA_W'(sat));
      write_register(tlsv_pkg::CSR_SAT_GAIN, gain);
      write_register(tlsv_pkg::CSR_VIB_GAIN, vib);
      csr_write_enable <= 1'b0;
   endtask

   // The result side draws a stall for every item, so stalls land both while a
   // result waits and while the output is empty. It starts once reset is over.
   initial begin : result_sink
      int hold;
      rsp_stall <= 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         hold = draw_gap();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         tracker.match_pixel(rsp_item);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      tlsv_pkg::table_select_type lanes [3];
      bit tone, sat;
      logic [tlsv_pkg::CSR_DATA_W-1:0] gain, vib;
      lanes = '{tlsv_pkg::SEL_RED, tlsv_pkg::SEL_GREEN, tlsv_pkg::SEL_BLUE};
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_item <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= tlsv_pkg::CSR_TONE_ENABLE;
      csr_write_data <= '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Both stages off: pixels must pass straight through. A write with the
      // unused select must be dropped without producing a result.
      program_settings(1'b0, 1'b0, 18'h10000, 18'h00000);
      push_item(make_pixel(0, 0, 0, 0, 1'b0));
      push_item(make_pixel(255, 255, 255, 255, 1'b1));
      push_item(make_write(SEL_NONE, 255, 255));
      push_item(random_pixel());

      // Every tone entry is written before the tone stage is ever switched on,
      // so no pixel can read an entry whose contents are still undefined.
      foreach (lanes[l]) begin
         for (int idx = 0; idx < tlsv_pkg::TABLE_DEPTH; idx++) begin
            push_item(make_write(lanes[l], idx, $urandom_range(0, 255)));
         end
      end
      settle_block();

      // Tone stage alone, including a pixel that reads an entry written by the
      // item just before it.
      program_settings(1'b1, 1'b0, 18'h10000, 18'h00000);
      push_item(make_pixel(0, 0, 0, 17, 1'b0));
      push_item(make_pixel(255, 255, 255, 200, 1'b1));
      push_item(make_write(tlsv_pkg::SEL_RED, 7, 200));
      push_item(make_pixel(7, 7, 7, 1, 1'b0));
      settle_block();

      // Saturation at unity: a grey (no chroma), black (maximum of zero), a
      // fully saturated primary and an ordinary colour.
      program_settings(1'b0, 1'b1, 18'h10000, 18'h00000);
      push_item(make_pixel(128, 128, 128, 64, 1'b0));
      push_item(make_pixel(0, 0, 0, 0, 1'b0));
      push_item(make_pixel(255, 0, 0, 255, 1'b1));
      push_item(make_pixel(10, 200, 90, 3, 1'b0));
      settle_block();

      // Zero gain with the most negative in-range vibrance, then the top of
      // both ranges, then raw values outside the documented ranges.
      program_settings(1'b1, 1'b1, 18'h00000, 18'h30000);
      push_item(make_pixel(255, 0, 0, 9, 1'b0));
      push_item(make_pixel(30, 60, 90, 90, 1'b1));
      settle_block();
      program_settings(1'b0, 1'b1, 18'h20000, 18'h10000);
      push_item(make_pixel(255, 0, 0, 128, 1'b0));
      push_item(make_pixel(100, 120, 140, 127, 1'b0));
      push_item(make_pixel(50, 50, 50, 2, 1'b1));
      settle_block();
      program_settings(1'b1, 1'b1, 18'h3FFFF, 18'h20000);
      push_item(make_pixel(0, 255, 0, 77, 1'b0));
      push_item(make_pixel(1, 2, 3, 5, 1'b1));
      settle_block();
      program_settings(1'b0, 1'b1, 18'h00000, 18'h1FFFF);
      push_item(make_pixel(200, 10, 10, 44, 1'b0));
      settle_block();

      // Random phases. Each picks its settings with a bias towards the extremes,
      // then streams mostly pixels with some table writes mixed in.
      for (int phase = 0; phase < 5; phase++) begin
         tone = 1'($urandom_range(0, 1));
         sat = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 4))
            0: gain = 18'h00000;
            1: gain = 18'h20000;
            2: gain = 18'h10000;
            3: gain = tlsv_pkg::CSR_DATA_W'($urandom_range(0, 131072));
            default: gain = tlsv_pkg::CSR_DATA_W'($urandom);
         endcase
         case ($urandom_range(0, 4))
            0: vib = 18'h30000;
            1: vib = 18'h10000;
            2: vib = 18'h00000;
            3: vib = tlsv_pkg::CSR_DATA_W'($urandom_range(0, 131072) - 65536);
            default: vib = tlsv_pkg::CSR_DATA_W'($urandom);
         endcase
         program_settings(tone, sat, gain, vib);
         for (int n = 0; n < 250; n++) begin
            // Every fifty items decide afresh whether both sides run flat out.
            if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
            // Once, the sender holds off mid-phase until the pipeline is empty.
            if (phase == 3 && n == 125) settle_block();
            if ($urandom_range(0, 6) == 0) push_item(random_write());
            else push_item(random_pixel());
         end
         quiet = 1'b0;
         settle_block();
      end

      if (tracker.mismatches == 0) begin
         $display("[tone_lut_saturation_vibrance_core] OK");
      end else begin
         $display("[tone_lut_saturation_vibrance_core] ERROR");
      end
      $finish;
   end

   // A run that is healthy finishes far inside this bound.
   initial begin : watchdog
      #20_000_000;
      $display("[tone_lut_saturation_vibrance_core] ERROR");
      $finish;
   end

endmodule
